@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

@@ src/bbsgd_pkg.sv @@
// Shared types, constants and arithmetic helpers of the bias SGD block.
// No dependencies; imported by the controller, datapath and top level.
package bbsgd_pkg;

    // Table depths and derived address widths
    localparam int unsigned USER_DEPTH = 65536;
    localparam int unsigned ITEM_DEPTH = 16384;
    localparam int          USER_AW    = $clog2(USER_DEPTH);
    localparam int          ITEM_AW    = $clog2(ITEM_DEPTH);
    localparam int unsigned CLR_DEPTH  = (USER_DEPTH > ITEM_DEPTH) ? USER_DEPTH : ITEM_DEPTH;
    localparam int          CLR_AW     = $clog2(CLR_DEPTH);

    // Reciprocals for index reduction, floor(2^32 / depth)
    localparam logic [31:0] USER_RECIP = 32'((64'd1 << 32) / USER_DEPTH);
    localparam logic [31:0] ITEM_RECIP = 32'((64'd1 << 32) / ITEM_DEPTH);

    // Field widths
    localparam int IDX_W   = 16;
    localparam int UIDX_W  = 16;
    localparam int IIDX_W  = 14;
    localparam int RATE_W  = 3;
    localparam int GM_W    = 15;
    localparam int COEF_W  = 16;
    localparam int BIAS_W  = 16;
    localparam int PRED_W  = 15;
    localparam int ERR_W   = 16;
    localparam int SQ_W    = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Internal arithmetic widths
    localparam int RED_W  = 21;             // holds any depth up to 2^20
    localparam int SUM_W  = 18;             // mean + two biases
    localparam int PROD_W = 35;             // Q7.28 products
    localparam int RND_W  = PROD_W - 16;    // product back in Q7.12
    localparam int DIFF_W = 20;             // error - decay
    localparam int NB_W   = 20;             // bias + delta before saturation

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_MEAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZATION = 2'd2;

    localparam logic [GM_W-1:0]   GM_RESET    = 15'd14746;
    localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd328;
    localparam logic [COEF_W-1:0] BETA_RESET  = 16'd131;

    // Prediction limits, 1.0 and 5.0 in Q4.12
    localparam logic signed [SUM_W-1:0] ONE_Q12  = 18'sd4096;
    localparam logic signed [SUM_W-1:0] FIVE_Q12 = 18'sd20480;
    localparam logic [SQ_W-1:0]         SQ_MAX   = 29'h1FFF_FFFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_PRED,
        ST_MUL1,
        ST_MUL2,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic reduce;
        logic read;
        logic predict;
        logic mul1;
        logic mul2;
        logic write;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic predict_only;
    } t_stat;

    // Approximate quotient x / depth, low by at most one
    function automatic logic [IDX_W-1:0] f_quot(input logic [IDX_W-1:0] x,
                                                input logic [31:0] recip);
        logic [IDX_W+31:0] p;
        p = (IDX_W+32)'(x) * (IDX_W+32)'(recip);
        return p[IDX_W+31:32];
    endfunction

    // Remainder from the approximate quotient: one compare and subtract
    function automatic logic [RED_W-1:0] f_reduce(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] q,
                                                  input int unsigned depth);
        logic [IDX_W+RED_W-1:0] qd;
        logic [RED_W-1:0]       r;
        qd = (IDX_W+RED_W)'(q) * (IDX_W+RED_W)'(depth);
        r  = RED_W'(x) - qd[RED_W-1:0];
        if (r >= RED_W'(depth)) begin
            r = r - RED_W'(depth);
        end
        return r;
    endfunction

    // floor((x + 2^15) / 2^16): halves round towards plus infinity
    function automatic logic signed [RND_W-1:0] f_round_q16(
        input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + PROD_W'(32768);
        return t[PROD_W-1:16];
    endfunction

    function automatic logic [BIAS_W-1:0] f_sat_bias(input logic signed [NB_W-1:0] v);
        logic [BIAS_W-1:0] r;
        if (v > NB_W'(32767)) begin
            r = 16'h7FFF;
        end else if (v < NB_W'(-32768)) begin
            r = 16'h8000;
        end else begin
            r = v[BIAS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ src/bbsgd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced twice by the datapath for the bias tables.
module bbsgd_ram #(
    parameter  int DEPTH = 2,
    parameter  int WIDTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/bbsgd_ctrl.sv @@
// Sequencer of the bias SGD block: clearing pass, then one rating at a time.
// Depends on bbsgd_pkg (state type, command and status structs).
module bbsgd_ctrl import bbsgd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_PRED;
            end
            ST_PRED: begin
                o_cmd.predict = 1'b1;
                n_state       = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                o_cmd.emit = 1'b1;
                // predict-only words end here
                n_state = i_stat.predict_only ? ST_IDLE : ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE) || !i_rst_n;

endmodule

@@ src/bbsgd_dpath.sv @@
// Datapath of the bias SGD block: config registers, index reduction, bias
// tables, prediction, error and bias update. Depends on bbsgd_pkg, bbsgd_ram.
module bbsgd_dpath import bbsgd_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_stat                        o_stat,
    input  logic                         i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_action,
    input  logic [UIDX_W-1:0]            i_user_index,
    input  logic [IIDX_W-1:0]            i_item_index,
    input  logic [RATE_W-1:0]            i_rating_value,
    output logic                         o_result_valid,
    output logic [PRED_W-1:0]            o_prediction,
    output logic signed [ERR_W-1:0]      o_error,
    output logic [SQ_W-1:0]              o_squared_error
);

    // configuration
    logic [GM_W-1:0]   r_gm;
    logic [COEF_W-1:0] r_alpha;
    logic [COEF_W-1:0] r_beta;

    // control
    logic              r_valid;
    logic [CLR_AW-1:0] r_clr_cnt;

    // payload
    logic              r_action;
    logic [RATE_W-1:0] r_rating;
    logic [IDX_W-1:0]  r_uidx;
    logic [IDX_W-1:0]  r_iidx;
    logic [IDX_W-1:0]  r_uq;
    logic [IDX_W-1:0]  r_iq;
    logic [USER_AW-1:0] r_uaddr;
    logic [ITEM_AW-1:0] r_iaddr;
    logic [PRED_W-1:0] r_pred;
    logic signed [ERR_W-1:0]  r_err;
    logic [SQ_W-1:0]          r_sq;
    logic signed [PROD_W-1:0] r_decay_u;
    logic signed [PROD_W-1:0] r_decay_i;
    logic signed [PROD_W-1:0] r_prod_u;
    logic signed [PROD_W-1:0] r_prod_i;

    // combinational
    logic [BIAS_W-1:0]        w_ub_rd;
    logic [BIAS_W-1:0]        w_ib_rd;
    logic signed [BIAS_W-1:0] s_ub;
    logic signed [BIAS_W-1:0] s_ib;
    logic signed [COEF_W:0]   s_alpha;
    logic signed [COEF_W:0]   s_beta;
    logic signed [SUM_W-1:0]  w_sum;
    logic [PRED_W-1:0]        w_pred;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [2*ERR_W-1:0] w_sq;
    logic signed [DIFF_W-1:0] w_diff_u;
    logic signed [DIFF_W-1:0] w_diff_i;
    logic signed [NB_W-1:0]   w_nb_u;
    logic signed [NB_W-1:0]   w_nb_i;
    logic                     w_u_we;
    logic                     w_i_we;
    logic [USER_AW-1:0]       w_u_waddr;
    logic [ITEM_AW-1:0]       w_i_waddr;
    logic [BIAS_W-1:0]        w_u_wdata;
    logic [BIAS_W-1:0]        w_i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm    <= GM_RESET;
            r_alpha <= ALPHA_RESET;
            r_beta  <= BETA_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GLOBAL_MEAN:    r_gm    <= i_cfg_data[GM_W-1:0];
                CFG_LEARN_RATE:     r_alpha <= i_cfg_data[COEF_W-1:0];
                CFG_REGULARIZATION: r_beta  <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_clr_cnt <= '0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    assign o_stat.clr_last     = (r_clr_cnt == CLR_AW'(CLR_DEPTH - 1));
    assign o_stat.predict_only = r_action;

    // word capture and index reduction; quotient estimate registered straight after its multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_rating <= i_rating_value;
            r_uidx   <= i_user_index;
            r_iidx   <= IDX_W'(i_item_index);
            r_uq     <= f_quot(i_user_index, USER_RECIP);
            r_iq     <= f_quot(IDX_W'(i_item_index), ITEM_RECIP);
        end
        if (i_cmd.reduce) begin
            r_uaddr <= USER_AW'(f_reduce(r_uidx, r_uq, USER_DEPTH));
            r_iaddr <= ITEM_AW'(f_reduce(r_iidx, r_iq, ITEM_DEPTH));
        end
    end

    assign s_ub    = signed'(w_ub_rd);
    assign s_ib    = signed'(w_ib_rd);
    assign s_alpha = signed'({1'b0, r_alpha});
    assign s_beta  = signed'({1'b0, r_beta});

    // prediction and error
    always_comb begin
        w_sum = SUM_W'(signed'({1'b0, r_gm})) + SUM_W'(s_ub) + SUM_W'(s_ib);
        if (w_sum < ONE_Q12) begin
            w_pred = PRED_W'(ONE_Q12);
        end else if (w_sum > FIVE_Q12) begin
            w_pred = PRED_W'(FIVE_Q12);
        end else begin
            w_pred = w_sum[PRED_W-1:0];
        end
        w_err = signed'({1'b0, r_rating, 12'b0}) - signed'({1'b0, w_pred});
    end

    assign w_sq = (2*ERR_W)'(r_err) * (2*ERR_W)'(r_err);

    assign w_diff_u = DIFF_W'(r_err) - DIFF_W'(f_round_q16(r_decay_u));
    assign w_diff_i = DIFF_W'(r_err) - DIFF_W'(f_round_q16(r_decay_i));

    assign w_nb_u = NB_W'(s_ub) + NB_W'(f_round_q16(r_prod_u));
    assign w_nb_i = NB_W'(s_ib) + NB_W'(f_round_q16(r_prod_i));

    always_ff @(posedge i_clk) begin
        if (i_cmd.predict) begin
            r_pred <= w_pred;
            r_err  <= w_err;
        end
        if (i_cmd.mul1) begin
            r_sq      <= (w_sq > (2*ERR_W)'(SQ_MAX)) ? SQ_MAX : w_sq[SQ_W-1:0];
            r_decay_u <= PROD_W'(s_ub) * PROD_W'(s_beta);
            r_decay_i <= PROD_W'(s_ib) * PROD_W'(s_beta);
        end
        if (i_cmd.mul2) begin
            r_prod_u <= PROD_W'(w_diff_u) * PROD_W'(s_alpha);
            r_prod_i <= PROD_W'(w_diff_i) * PROD_W'(s_alpha);
        end
    end

    // table write: zero during the clearing pass, updated bias afterwards
    always_comb begin
        if (i_cmd.clr_step) begin
            w_u_we    = ({1'b0, r_clr_cnt} < (CLR_AW+1)'(USER_DEPTH));
            w_i_we    = ({1'b0, r_clr_cnt} < (CLR_AW+1)'(ITEM_DEPTH));
            w_u_waddr = r_clr_cnt[USER_AW-1:0];
            w_i_waddr = r_clr_cnt[ITEM_AW-1:0];
            w_u_wdata = '0;
            w_i_wdata = '0;
        end else begin
            w_u_we    = i_cmd.write;
            w_i_we    = i_cmd.write;
            w_u_waddr = r_uaddr;
            w_i_waddr = r_iaddr;
            w_u_wdata = f_sat_bias(w_nb_u);
            w_i_wdata = f_sat_bias(w_nb_i);
        end
    end

    bbsgd_ram #(
        .DEPTH (USER_DEPTH),
        .WIDTH (BIAS_W)
    ) u_user_ram (
        .i_clk   (i_clk),
        .i_we    (w_u_we),
        .i_waddr (w_u_waddr),
        .i_wdata (w_u_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (r_uaddr),
        .o_rdata (w_ub_rd)
    );

    bbsgd_ram #(
        .DEPTH (ITEM_DEPTH),
        .WIDTH (BIAS_W)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_i_we),
        .i_waddr (w_i_waddr),
        .i_wdata (w_i_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (r_iaddr),
        .o_rdata (w_ib_rd)
    );

    assign o_result_valid  = r_valid;
    assign o_prediction    = r_pred;
    assign o_error         = r_err;
    assign o_squared_error = r_sq;

endmodule

@@ src/bias_baseline_sgd_update.sv @@
// Top level of the baseline-predictor bias learner (user and item bias SGD).
// Depends on bbsgd_pkg, bbsgd_ctrl, bbsgd_dpath (and bbsgd_ram below it).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  rating   | start / busy              | action, user_index, item_index, rating
//  result   | o_result_valid (strobe)   | prediction, error, squared_error
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A rating word is taken when start is high and busy low. Index reduction, the
// registered table read, the prediction and the first multiply (beta*bias) come
// before the result strobe, which lasts one cycle; the receiver cannot
// stall it. Train words then run the second multiply (alpha*difference) and write
// both tables back before busy falls, so a new word is taken only once the last
// is through; predict-only words skip the update. After reset both tables
// are zeroed by a clearing pass over max(USER_DEPTH, ITEM_DEPTH) addresses
// (65536 as built), busy high throughout; config writes are taken at any
// time outside reset.
module bias_baseline_sgd_update import bbsgd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // rating word
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_action,
    input  logic [UIDX_W-1:0]       i_user_index,
    input  logic [IIDX_W-1:0]       i_item_index,
    input  logic [RATE_W-1:0]       i_rating_value,
    // result word
    output logic                    o_result_valid,
    output logic [PRED_W-1:0]       o_prediction,
    output logic signed [ERR_W-1:0] o_error,
    output logic [SQ_W-1:0]         o_squared_error,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // registers take a write in any cycle outside reset
    assign o_cfg_ready = i_rst_n;

    bbsgd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    bbsgd_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_user_index    (i_user_index),
        .i_item_index    (i_item_index),
        .i_rating_value  (i_rating_value),
        .o_result_valid  (o_result_valid),
        .o_prediction    (o_prediction),
        .o_error         (o_error),
        .o_squared_error (o_squared_error)
    );

endmodule

@@ src/bbsgd_checker.sv @@
// Port-level checker for the bias SGD block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bbsgd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_valid,
    input logic [14:0]        o_prediction,
    input logic signed [15:0] o_error,
    input logic [28:0]        o_squared_error
);

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (start && !busy) |=> busy, "no busy after accept")
    `ASSERT_CLK(a_result_latency, i_clk, i_rst_n, (start && !busy) |-> ##5 o_result_valid, "result late")
    `ASSERT_CLK(a_single_strobe, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "strobe too long")
    `ASSERT_NEVER(a_pred_range, i_clk, i_rst_n, o_result_valid && (o_prediction < 15'd4096 || o_prediction > 15'd20480), "prediction out of range")
    `ASSERT_CLK(a_sq_zero, i_clk, i_rst_n, o_result_valid |-> ((o_squared_error == 29'd0) == (o_error == 16'sd0)), "squared error mismatch")

endmodule

bind bias_baseline_sgd_update bbsgd_checker u_bbsgd_checker (.*);
